// ===== design/mpmp_pkg.sv =====
// Types and constants shared by the min-plus matrix product block.
package mpmp_pkg;

  localparam int MaxK    = 64;
  localparam int MaxCols = 64;
  localparam int ValBits = 16;
  localparam int KW      = $clog2(MaxK);
  localparam int ColW    = $clog2(MaxCols);
  localparam int CfgW    = 7;
  localparam int CntW    = $clog2(MaxCols + 1);

  localparam logic [ValBits-1:0] ValInf = {ValBits{1'b1}};

  localparam logic [CfgW-1:0] InnerLenRst = CfgW'(64);
  localparam logic [CfgW-1:0] ColCountRst = CfgW'(64);

  typedef enum logic {
    REG_INNER_LEN = 1'b0,
    REG_COL_COUNT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    REQ_LOAD_B = 1'b0,
    REQ_A_ELEM = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic              req_type;
    logic [5:0]        k_index;
    logic [5:0]        col_index;
    logic [15:0]       value;
    logic              row_last;
  } in_t;

  typedef struct packed {
    logic [15:0] c_value;
    logic [5:0]  out_col;
    logic        out_last;
  } out_t;

  // token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               is_a;
    logic               use_k;
    logic               last;
    logic [KW-1:0]      k;
    logic [ColW-1:0]    col;
    logic [ValBits-1:0] value;
  } tok_t;

endpackage

// ===== design/min_plus_matrix_product_top.sv =====
// Top level of the min-plus matrix product block: cell chain, row drain and ports.
// Every beat enters a chain of 64 column cells and moves one cell per cycle; B loads
// and A elements stream in at one beat per cycle. A row-last A element stops intake
// for its trip down the chain plus the drain of col_count results (at most 64), one per
// cycle while the output is not stalled; intake resumes once the drain count reaches
// col_count and the state machine returns from drain to run.
module min_plus_matrix_product_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  mpmp_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mpmp_pkg::out_t               out_data_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [mpmp_pkg::CfgW-1:0]    cfg_data_i
);

  logic [mpmp_pkg::CfgW-1:0]    inner_len_q;
  logic [mpmp_pkg::CfgW-1:0]    col_count_q;
  logic [mpmp_pkg::CntW-1:0]    ccount;
  mpmp_pkg::state_e             state_q, state_d;
  logic [mpmp_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  mpmp_pkg::out_t               out_data_q, out_data_d;
  logic                         in_acc;
  logic                         drain_go;
  logic                         tail_last;
  mpmp_pkg::tok_t               tok_w [mpmp_pkg::MaxCols+1];
  logic [mpmp_pkg::ValBits-1:0] hold_w [mpmp_pkg::MaxCols+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_len_q <= mpmp_pkg::InnerLenRst;
      col_count_q <= mpmp_pkg::ColCountRst;
    end else if (cfg_we_i) begin
      unique case (mpmp_pkg::reg_idx_e'(cfg_idx_i))
        mpmp_pkg::REG_INNER_LEN: inner_len_q <= cfg_data_i;
        mpmp_pkg::REG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ccount = (col_count_q > mpmp_pkg::CfgW'(mpmp_pkg::MaxCols))
                ? mpmp_pkg::CntW'(mpmp_pkg::MaxCols)
                : mpmp_pkg::CntW'(col_count_q);

  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    tok_w[0].vld   = in_acc;
    tok_w[0].is_a  = (in_data_i.req_type == mpmp_pkg::REQ_A_ELEM);
    tok_w[0].use_k = ({1'b0, in_data_i.k_index} < inner_len_q);
    tok_w[0].last  = in_data_i.row_last;
    tok_w[0].k     = in_data_i.k_index;
    tok_w[0].col   = in_data_i.col_index;
    tok_w[0].value = in_data_i.value;
  end

  assign hold_w[mpmp_pkg::MaxCols] = mpmp_pkg::ValInf;

  for (genvar g = 0; g < mpmp_pkg::MaxCols; g++) begin : g_cell
    mpmp_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .col_id_i (mpmp_pkg::ColW'(g)),
      .tok_i    (tok_w[g]),
      .tok_o    (tok_w[g+1]),
      .shift_i  (drain_go),
      .hold_i   (hold_w[g+1]),
      .hold_o   (hold_w[g])
    );
  end

  assign tail_last = tok_w[mpmp_pkg::MaxCols].vld && tok_w[mpmp_pkg::MaxCols].is_a
                  && tok_w[mpmp_pkg::MaxCols].last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpmp_pkg::ST_RUN: begin
        if (in_acc && in_data_i.req_type == mpmp_pkg::REQ_A_ELEM && in_data_i.row_last) begin
          state_d = mpmp_pkg::ST_FLUSH;
        end
      end
      mpmp_pkg::ST_FLUSH: begin
        if (tail_last) begin
          state_d = mpmp_pkg::ST_DRAIN;
        end
      end
      mpmp_pkg::ST_DRAIN: begin
        if (cnt_q == ccount) begin
          state_d = mpmp_pkg::ST_RUN;
        end
      end
      default: state_d = mpmp_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != mpmp_pkg::ST_RUN);
    drain_go   = (state_q == mpmp_pkg::ST_DRAIN) && (!out_valid_q || !out_stall_i)
              && (cnt_q != ccount);
    cnt_d      = ((state_q == mpmp_pkg::ST_DRAIN) && (cnt_q != ccount)) ? cnt_q : '0;
    if (drain_go) begin
      cnt_d = cnt_q + 1'b1;
    end
    out_data_d          = out_data_q;
    out_valid_d         = out_valid_q && out_stall_i;
    if (drain_go) begin
      out_valid_d         = 1'b1;
      out_data_d.c_value  = hold_w[0];
      out_data_d.out_col  = cnt_q[mpmp_pkg::ColW-1:0];
      out_data_d.out_last = (cnt_q + 1'b1 == ccount);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpmp_pkg::ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_drain_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpmp_pkg::ST_DRAIN) |-> !tok_w[mpmp_pkg::MaxCols].vld)
    else $error("beat still in cell chain during row drain");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ccount)
    else $error("drain count beyond column count");

  a_run_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpmp_pkg::ST_RUN) |-> (cnt_q == '0))
    else $error("drain count not cleared while taking beats");

  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_go && out_data_d.out_last) |=> (state_q == mpmp_pkg::ST_DRAIN)
      && (cnt_q == ccount))
    else $error("last column sent without closing the drain");

endmodule

// ===== design/mpmp_cell.sv =====
// One column cell: B column slice, accumulator and result hold register.
module mpmp_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mpmp_pkg::ColW-1:0]    col_id_i,
  input  mpmp_pkg::tok_t               tok_i,
  output mpmp_pkg::tok_t               tok_o,
  input  logic                         shift_i,
  input  logic [mpmp_pkg::ValBits-1:0] hold_i,
  output logic [mpmp_pkg::ValBits-1:0] hold_o
);

  logic [mpmp_pkg::ValBits-1:0] mem_q [mpmp_pkg::MaxK];
  logic [mpmp_pkg::ValBits-1:0] rd_q;
  logic [mpmp_pkg::ValBits-1:0] acc_q, acc_d;
  logic [mpmp_pkg::ValBits-1:0] hold_q, hold_d;
  mpmp_pkg::tok_t               tok_q;
  logic [mpmp_pkg::ValBits:0]   sum;
  logic [mpmp_pkg::ValBits-1:0] sat;
  logic [mpmp_pkg::ValBits-1:0] cand;
  logic                         upd;
  logic                         snap;

  always_ff @(posedge clk_i) begin
    if (tok_i.vld && !tok_i.is_a && tok_i.col == col_id_i) begin
      mem_q[tok_i.k] <= tok_i.value;
    end
    rd_q <= mem_q[tok_i.k];
  end

  always_comb begin
    sum  = {1'b0, tok_q.value} + {1'b0, rd_q};
    sat  = (sum >= {1'b0, mpmp_pkg::ValInf}) ? mpmp_pkg::ValInf
                                              : sum[mpmp_pkg::ValBits-1:0];
    upd  = tok_q.vld && tok_q.is_a && tok_q.use_k && (sat < acc_q);
    cand = upd ? sat : acc_q;
    snap = tok_q.vld && tok_q.is_a && tok_q.last;
    acc_d = snap ? mpmp_pkg::ValInf : cand;
    if (shift_i) begin
      hold_d = hold_i;
    end else if (snap) begin
      hold_d = cand;
    end else begin
      hold_d = hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      acc_q <= mpmp_pkg::ValInf;
    end else begin
      tok_q <= tok_i;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  assign tok_o  = tok_q;
  assign hold_o = hold_q;

endmodule
